// ===== src/chm_pkg.sv =====
// shared types and codes for the chained hash map
package chm_pkg;

    localparam int NODE_CAPACITY_DEF = 256;

    localparam int REQ_W    = 2;
    localparam int KEY_W    = 31;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [VALUE_W-1:0]  value_out;
    } rsp_t;

    // request token that travels down the row of cells, one cell per cycle
    typedef struct packed {
        logic               live;
        logic [REQ_W-1:0]   req_type;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic               done;
        logic               hit;
        logic               shift;
    } tok_t;

    // one stored node
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

endpackage

// ===== src/chm_cell.sv =====
// one node cell: holds a key/value entry and passes the request token on
module chm_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  chm_pkg::tok_t   tok_in,
    output chm_pkg::tok_t   tok_out,
    input  chm_pkg::entry_t right_entry,
    output chm_pkg::entry_t entry
);
    import chm_pkg::*;

    tok_t   tok_reg;
    tok_t   tok_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   key_match;

    assign key_match = entry_reg.valid && (entry_reg.key == tok_in.key);

    always_comb
    begin
        tok_next   = tok_in;
        entry_next = entry_reg;
        // a removal ahead of us is closing the gap: take the right neighbor's entry
        if (tok_reg.live && tok_reg.shift)
        begin
            entry_next = right_entry;
        end
        else if (tok_in.live && !tok_in.done)
        begin
            case (tok_in.req_type)
                REQ_INSERT:
                begin
                    if (!entry_reg.valid)
                    begin
                        entry_next.valid = 1'b1;
                        entry_next.key   = tok_in.key;
                        entry_next.value = tok_in.value;
                        tok_next.done    = 1'b1;
                    end
                end
                REQ_SEARCH:
                begin
                    if (key_match)
                    begin
                        tok_next.done  = 1'b1;
                        tok_next.hit   = 1'b1;
                        tok_next.value = entry_reg.value;
                    end
                end
                REQ_REMOVE:
                begin
                    if (key_match)
                    begin
                        tok_next.done  = 1'b1;
                        tok_next.hit   = 1'b1;
                        tok_next.shift = 1'b1;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            entry_reg <= '0;
        end
        else
        begin
            tok_reg   <= tok_next;
            entry_reg <= entry_next;
        end
    end

    assign tok_out = tok_reg;
    assign entry   = entry_reg;

`ifndef ASSERT_OFF
    // occupied cells stay packed toward the head of the row
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        right_entry.valid |-> entry_reg.valid)
        else $error("occupied cell to the right of an empty one");

    // a cell only pulls from its neighbor when no token sits at its input
    a_pull_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_reg.live && tok_reg.shift) |-> !tok_in.live)
        else $error("pull collides with a token at the cell input");

    a_shift_src: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_reg.live && tok_reg.shift) |-> (tok_reg.hit && tok_reg.req_type == REQ_REMOVE))
        else $error("shift without a matching remove");
`endif

endmodule

// ===== src/chained_hash_map.sv =====
// chained hash map top level: request port, row of node cells, response register
// the request token is registered in every cell in turn; the response register loads as the token leaves the last cell
// a new item is taken only once the token has walked every cell, and not while a held response is stalled
// the map holds NODE_CAPACITY nodes in oldest-first order; duplicates are kept
// reset: asynchronous, all cells empty and no item in flight
module chained_hash_map #(
    parameter int NODE_CAPACITY = chm_pkg::NODE_CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  chm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output chm_pkg::rsp_t rsp
);
    import chm_pkg::*;

    tok_t   chain_tok [NODE_CAPACITY+1];
    entry_t cell_entry [NODE_CAPACITY+1];
    tok_t   exit_tok;
    logic   req_accept;
    logic   walk_reg;
    logic   walk_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    rsp_t   rsp_reg;
    rsp_t   rsp_next;
    logic [NODE_CAPACITY-1:0] live_vec;

    assign req_stall  = walk_reg || (rsp_valid_reg && rsp_stall);
    assign req_accept = req_valid && !req_stall;

    // launch the token straight into the first cell
    always_comb
    begin
        chain_tok[0]          = '0;
        chain_tok[0].live     = req_accept;
        chain_tok[0].req_type = req.req_type;
        chain_tok[0].key      = req.key;
        chain_tok[0].value    = req.value;
    end

    assign cell_entry[NODE_CAPACITY] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NODE_CAPACITY; gi++)
        begin : g_cell
            chm_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .tok_in      (chain_tok[gi]),
                .tok_out     (chain_tok[gi+1]),
                .right_entry (cell_entry[gi+1]),
                .entry       (cell_entry[gi])
            );
            assign live_vec[gi] = chain_tok[gi+1].live;
        end
    endgenerate

    assign exit_tok = chain_tok[NODE_CAPACITY];

    always_comb
    begin
        rsp_next = '0;
        case (exit_tok.req_type)
            REQ_INSERT:
            begin
                // an insert that found no empty cell means the pool is full
                rsp_next.status = exit_tok.done ? STATUS_OK : STATUS_FULL;
            end
            REQ_SEARCH:
            begin
                rsp_next.status    = exit_tok.hit ? STATUS_OK : STATUS_NOT_FOUND;
                rsp_next.found     = exit_tok.hit;
                rsp_next.value_out = exit_tok.hit ? exit_tok.value : '0;
            end
            REQ_REMOVE:
            begin
                rsp_next.status = exit_tok.hit ? STATUS_OK : STATUS_NOT_FOUND;
                rsp_next.found  = exit_tok.hit;
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_comb
    begin
        walk_next = walk_reg;
        if (req_accept)
        begin
            walk_next = 1'b1;
        end
        else if (exit_tok.live)
        begin
            walk_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (exit_tok.live)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            walk_reg      <= walk_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exit_tok.live)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(live_vec))
        else $error("more than one token in the cell row");

    a_exit_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        exit_tok.live |-> walk_reg)
        else $error("token left the row with no walk in progress");

    a_exit_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        exit_tok.live |=> (rsp_valid_reg && !walk_reg))
        else $error("finished walk did not load the response");
`endif

endmodule
